// File: rtl/core/fsjrp_pkg.sv
// fsjrp_pkg: shared types, codes and the field name rom of the json record parser
// no dependencies; imported by every module in rtl/core
package fsjrp_pkg;

  localparam int unsigned NumFields = 8;
  localparam int unsigned MaxNameLen = 20;

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_CLOSE  = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_STRUCTURE = 3'd1,
    ST_CONTROL   = 3'd2,
    ST_ESCAPE    = 3'd3,
    ST_CUT       = 3'd4,
    ST_UNTERM    = 3'd5,
    ST_NAME      = 3'd6,
    ST_PAYLOAD   = 3'd7
  } status_e;

  typedef enum logic [3:0] {
    PH_OPEN        = 4'd0,
    PH_NAME_QUOTE  = 4'd1,
    PH_NAME        = 4'd2,
    PH_NAME_ESC    = 4'd3,
    PH_COLON       = 4'd4,
    PH_VALUE_QUOTE = 4'd5,
    PH_VALUE       = 4'd6,
    PH_VALUE_ESC   = 4'd7,
    PH_SEPARATOR   = 4'd8,
    PH_DONE        = 4'd9
  } phase_e;

  typedef enum logic {
    ACT_BYTE = 1'b0,
    ACT_END  = 1'b1
  } action_e;

  typedef struct packed {
    logic       action;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    kind_e      result_kind;
    logic [2:0] field_index;
    logic [7:0] value_byte;
    status_e    status;
  } out_item_t;

  // classified input beat, handed from front to back
  typedef struct packed {
    logic       is_end;
    logic [7:0] data;
    logic       space;
    logic       quote;
    logic       bslash;
    logic       ctrl;
    logic       lbrace;
    logic       rbrace;
    logic       colon;
    logic       comma;
    logic       esc_ok;
    logic [7:0] esc_data;
  } cls_t;

  localparam logic [2:0] LastField = 3'(NumFields - 1);

  function automatic logic [4:0] key_len(logic [2:0] f);
    logic [4:0] n;
    unique case (f)
      3'd0:    n = 5'd7;
      3'd1:    n = 5'd7;
      3'd2:    n = 5'd6;
      3'd3:    n = 5'd20;
      3'd4:    n = 5'd18;
      3'd5:    n = 5'd11;
      3'd6:    n = 5'd14;
      default: n = 5'd13;
    endcase
    return n;
  endfunction

  // byte p of the name of field f, zero past its end
  function automatic logic [7:0] key_char(logic [2:0] f, logic [4:0] p);
    logic [8*MaxNameLen-1:0] s;
    logic [4:0]              n;
    logic [7:0]              sh;
    unique case (f)
      3'd0:    s = (8*MaxNameLen)'("version");
      3'd1:    s = (8*MaxNameLen)'("subject");
      3'd2:    s = (8*MaxNameLen)'("issuer");
      3'd3:    s = (8*MaxNameLen)'({"public_key", "_algorithm"});
      3'd4:    s = (8*MaxNameLen)'({"public_key", "_pem_b64"});
      3'd5:    s = (8*MaxNameLen)'({"created", "_utc"});
      3'd6:    s = (8*MaxNameLen)'({"not_before", "_utc"});
      default: s = (8*MaxNameLen)'({"not_after", "_utc"});
    endcase
    n  = key_len(f);
    sh = {3'b000, 5'(n - 5'd1 - p)} << 3;
    return (p < n) ? s[sh +: 8] : 8'h00;
  endfunction

endpackage

// File: rtl/core/fsjrp_classify.sv
// fsjrp_classify: front end, sorts each input beat into character classes
// and decodes the escape that would follow a backslash; uses fsjrp_pkg
module fsjrp_classify import fsjrp_pkg::*; (
  input  in_item_t item_i,
  output cls_t     cls_o
);

  logic [7:0] b;
  assign b = item_i.in_byte;

  always_comb begin
    cls_o          = '0;
    cls_o.is_end   = (item_i.action == ACT_END);
    cls_o.data     = b;
    cls_o.space    = (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0D);
    cls_o.quote    = (b == 8'h22);
    cls_o.bslash   = (b == 8'h5C);
    cls_o.ctrl     = (b < 8'h20);
    cls_o.lbrace   = (b == 8'h7B);
    cls_o.rbrace   = (b == 8'h7D);
    cls_o.colon    = (b == 8'h3A);
    cls_o.comma    = (b == 8'h2C);
    cls_o.esc_ok   = 1'b1;
    unique case (b)
      8'h22:   cls_o.esc_data = 8'h22;
      8'h5C:   cls_o.esc_data = 8'h5C;
      8'h2F:   cls_o.esc_data = 8'h2F;
      8'h62:   cls_o.esc_data = 8'h08;
      8'h66:   cls_o.esc_data = 8'h0C;
      8'h6E:   cls_o.esc_data = 8'h0A;
      8'h72:   cls_o.esc_data = 8'h0D;
      8'h74:   cls_o.esc_data = 8'h09;
      default: begin
        cls_o.esc_data = 8'h00;
        cls_o.esc_ok   = 1'b0;
      end
    endcase
  end

endmodule

// File: rtl/core/fsjrp_queue.sv
// fsjrp_queue: small fifo of classified beats between front and back
// uses fsjrp_pkg for the beat type
module fsjrp_queue import fsjrp_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cls_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cls_t pop_data_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [CntW-1:0]  Full     = CntW'(Depth);

  cls_t             mem_q [Depth];
  logic [AddrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != Full);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = push ? ((wr_q == LastAddr) ? '0 : wr_q + 1'b1) : wr_q;
    rd_d  = pop  ? ((rd_q == LastAddr) ? '0 : rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// File: rtl/core/fsjrp_grammar.sv
// fsjrp_grammar: back end, grammar state machine, name compare, version check
// and the output register; uses fsjrp_pkg
module fsjrp_grammar import fsjrp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      item_valid_i,
  output logic      item_ready_o,
  input  cls_t      item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  phase_e     phase_q, phase_d;
  logic [2:0] field_q, field_d;
  logic [4:0] npos_q, npos_d;
  logic       nmis_q, nmis_d;
  logic [1:0] vlen_q, vlen_d;
  logic       vone_q, vone_d;
  status_e    err_q, err_d;

  logic       out_valid_q, out_valid_d;
  out_item_t  out_item_q, out_item_d;

  logic       pop;
  logic       res_valid;
  out_item_t  res;
  logic [7:0] name_b;
  logic       name_bad;
  logic [7:0] val_b;

  assign pop          = item_valid_i && (!out_valid_q || out_ready_i);
  assign item_ready_o = !out_valid_q || out_ready_i;

  // decoded byte for name compare, raw or escaped
  assign name_b   = (phase_q == PH_NAME_ESC) ? item_i.esc_data : item_i.data;
  assign name_bad = (npos_q >= key_len(field_q)) || (key_char(field_q, npos_q) != name_b);
  assign val_b    = (phase_q == PH_VALUE_ESC) ? item_i.esc_data : item_i.data;

  // next state
  always_comb begin
    phase_d = phase_q;
    field_d = field_q;
    npos_d  = npos_q;
    nmis_d  = nmis_q;
    vlen_d  = vlen_q;
    vone_d  = vone_q;
    err_d   = err_q;
    if (pop) begin
      if (item_i.is_end) begin
        phase_d = PH_OPEN;
        field_d = '0;
        npos_d  = '0;
        nmis_d  = 1'b0;
        vlen_d  = '0;
        vone_d  = 1'b0;
        err_d   = ST_OK;
      end else if (err_q == ST_OK) begin
        unique case (phase_q)
          PH_OPEN: begin
            if (!item_i.space) begin
              if (item_i.lbrace) phase_d = PH_NAME_QUOTE;
              else               err_d   = ST_STRUCTURE;
            end
          end
          PH_NAME_QUOTE: begin
            if (!item_i.space) begin
              if (item_i.quote) begin
                phase_d = PH_NAME;
                npos_d  = '0;
                nmis_d  = 1'b0;
              end else begin
                err_d = ST_STRUCTURE;
              end
            end
          end
          PH_NAME: begin
            priority if (item_i.quote) begin
              if (nmis_q || (npos_q != key_len(field_q))) err_d   = ST_NAME;
              else                                        phase_d = PH_COLON;
            end else if (item_i.ctrl) begin
              err_d = ST_CONTROL;
            end else if (item_i.bslash) begin
              phase_d = PH_NAME_ESC;
            end else begin
              if (name_bad) nmis_d = 1'b1;
              if (npos_q != 5'd31) npos_d = npos_q + 1'b1;
            end
          end
          PH_NAME_ESC: begin
            if (item_i.esc_ok) begin
              if (name_bad) nmis_d = 1'b1;
              if (npos_q != 5'd31) npos_d = npos_q + 1'b1;
              phase_d = PH_NAME;
            end else begin
              err_d = ST_ESCAPE;
            end
          end
          PH_COLON: begin
            if (!item_i.space) begin
              if (item_i.colon) phase_d = PH_VALUE_QUOTE;
              else              err_d   = ST_STRUCTURE;
            end
          end
          PH_VALUE_QUOTE: begin
            if (!item_i.space) begin
              if (item_i.quote) phase_d = PH_VALUE;
              else              err_d   = ST_STRUCTURE;
            end
          end
          PH_VALUE, PH_VALUE_ESC: begin
            priority if (phase_q == PH_VALUE && item_i.quote) begin
              phase_d = PH_SEPARATOR;
            end else if (phase_q == PH_VALUE && item_i.ctrl) begin
              err_d = ST_CONTROL;
            end else if (phase_q == PH_VALUE && item_i.bslash) begin
              phase_d = PH_VALUE_ESC;
            end else if (phase_q == PH_VALUE_ESC && !item_i.esc_ok) begin
              err_d = ST_ESCAPE;
            end else begin
              phase_d = PH_VALUE;
              if (field_q == '0) begin
                if (vlen_q == '0) vone_d = (val_b == 8'h31);
                if (vlen_q != 2'd3) vlen_d = vlen_q + 1'b1;
              end
            end
          end
          PH_SEPARATOR: begin
            if (!item_i.space) begin
              priority if (item_i.comma && field_q != LastField) begin
                field_d = field_q + 1'b1;
                phase_d = PH_NAME_QUOTE;
              end else if (item_i.rbrace && field_q == LastField) begin
                phase_d = PH_DONE;
                if (!(vlen_q == 2'd1 && vone_q)) err_d = ST_PAYLOAD;
              end else begin
                err_d = ST_STRUCTURE;
              end
            end
          end
          PH_DONE: begin
            if (!item_i.space) err_d = ST_PAYLOAD;
          end
          default: err_d = ST_STRUCTURE;
        endcase
      end
    end
  end

  // result of the current beat
  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    if (pop) begin
      if (item_i.is_end) begin
        res_valid       = 1'b1;
        res.result_kind = KIND_STATUS;
        if (err_q != ST_OK) begin
          res.status = err_q;
        end else begin
          unique case (phase_q)
            PH_NAME, PH_VALUE:         res.status = ST_UNTERM;
            PH_NAME_ESC, PH_VALUE_ESC: res.status = ST_CUT;
            PH_DONE:                   res.status = ST_OK;
            default:                   res.status = ST_STRUCTURE;
          endcase
        end
      end else if (err_q == ST_OK) begin
        if (phase_q == PH_VALUE) begin
          priority if (item_i.quote) begin
            res_valid       = 1'b1;
            res.result_kind = KIND_CLOSE;
            res.field_index = field_q;
          end else if (!item_i.ctrl && !item_i.bslash) begin
            res_valid       = 1'b1;
            res.result_kind = KIND_BYTE;
            res.field_index = field_q;
            res.value_byte  = val_b;
          end else begin
            res_valid = 1'b0;
          end
        end else if (phase_q == PH_VALUE_ESC && item_i.esc_ok) begin
          res_valid       = 1'b1;
          res.result_kind = KIND_BYTE;
          res.field_index = field_q;
          res.value_byte  = val_b;
        end
      end
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (pop) begin
      out_valid_d = res_valid;
      out_item_d  = res;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_OPEN;
      field_q     <= '0;
      npos_q      <= '0;
      nmis_q      <= 1'b0;
      vlen_q      <= '0;
      vone_q      <= 1'b0;
      err_q       <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      field_q     <= field_d;
      npos_q      <= npos_d;
      nmis_q      <= nmis_d;
      vlen_q      <= vlen_d;
      vone_q      <= vone_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// File: rtl/core/fixed_schema_json_record_parser.sv
// an accepted beat is first stored in the queue, then its result is held in the output register
// throughput: one beat per cycle while results are taken, set by the grammar step in the back end
// queue of QueueDepth beats decouples input from the grammar step and output register
// reset (async, active low): queue empty, no result pending, grammar expects opening brace
// no clearing pass after reset; input is taken from the first cycle out of reset
// top level: fsjrp_classify -> fsjrp_queue -> fsjrp_grammar, all using fsjrp_pkg
module fixed_schema_json_record_parser import fsjrp_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  // input beats: one text byte or end of input
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  // result beats: value byte, value close or final status
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  cls_t cls_in;
  cls_t cls_out;
  logic q_valid;
  logic q_ready;

  // front: character classes and escape decode, no state
  fsjrp_classify u_classify (
    .item_i (in_item_i),
    .cls_o  (cls_in)
  );

  // decoupling queue, front stalls only when it is full
  fsjrp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_ready_o (in_ready_o),
    .push_data_i  (cls_in),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (cls_out)
  );

  // back: grammar step, name rom compare, version check, error latch,
  // output register that pops the next beat while the current one is taken
  fsjrp_grammar u_grammar (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_ready_o (q_ready),
    .item_i       (cls_out),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_o   (out_item_o)
  );

endmodule
